// ----- src/rsape_pkg.sv -----
// ----------------------------------------------------------------------------
// rsape_pkg
// Shared exponent width and status codes for the RSA private exponent block.
// ----------------------------------------------------------------------------
package rsape_pkg;

	// Width of the public exponent and of the private exponent result.
	localparam int E_WIDTH = 64;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK             = 2'd0;
	localparam status_t ST_SMALL_TOTIENT  = 2'd1;
	localparam status_t ST_NOT_INVERTIBLE = 2'd2;

endpackage

// ----- src/rsa_private_exponent.sv -----
// ----------------------------------------------------------------------------
// rsa_private_exponent
// Private exponent d = e^-1 mod (p-1)(q-1) by the extended Euclidean method.
// ----------------------------------------------------------------------------
// Each request item carries primes p and q (low HALF_WIDTH bits used) and a
// public exponent e. The block multiplies out the totient, reduces e modulo
// the totient and then runs extended Euclid, giving one response item with d
// in 1..totient-1 and status ok, or d = 0 with status "totient below 2" (p or
// q below 2, or p = q = 2) or "not invertible" (gcd not 1). One item is in
// work at a time; req_ready is high only while the sequencer is idle, but a
// finished response may wait in the output register while the next request
// is accepted. All division runs through one shared compare-subtract unit
// that retires one quotient bit per cycle: the divisor is shifted up until it
// passes the remainder, then walked back down.
module rsa_private_exponent import rsape_pkg::*; #(
	parameter int HALF_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [31:0]          prime_p,
	input  logic [31:0]          prime_q,
	input  logic [E_WIDTH-1:0]   public_exp,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [E_WIDTH-1:0]   inverse,
	output status_t              status
);

	localparam int PW  = 2 * HALF_WIDTH;
	localparam int BSW = E_WIDTH + 1;
	localparam int TSW = PW + 1;
	localparam int KW  = $clog2(E_WIDTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_ALIGN = 3'd3;
	localparam logic [2:0] S_SUB   = 3'd4;
	localparam logic [2:0] S_NEXT  = 3'd5;
	localparam logic [2:0] S_ROUND = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]            state_q;
	logic [HALF_WIDTH-1:0] pm1_q, qm1_q;
	logic                  small_q;
	logic [PW-1:0]         phi_q;
	logic [PW-1:0]         prod;

	// Euclid registers: rem_q holds the running remainder (old a), b_q the
	// divisor; acc_q accumulates the new coefficient on top of ta.
	logic [E_WIDTH-1:0]    rem_q;
	logic [PW-1:0]         b_q;
	logic [PW-1:0]         acc_q;
	logic [PW-1:0]         tb_q;
	logic                  neg_a_q, neg_b_q;
	logic                  red_q;

	// Aligned divisor and coefficient, and the alignment count.
	logic [BSW-1:0]        bs_q;
	logic [TSW-1:0]        ts_q;
	logic [KW-1:0]         k_q;

	logic                  rsp_valid_q;
	logic [E_WIDTH-1:0]    inverse_q;
	status_t               status_q;

	logic [BSW-1:0]        bs_eff;
	logic [TSW-1:0]        ts_eff;
	logic                  fits;
	logic [E_WIDTH-1:0]    rem_diff;
	logic [PW-1:0]         acc_sum;

	logic [HALF_WIDTH-1:0] p_lo, q_lo;
	logic [PW-1:0]         t_mod, d_val;
	status_t               st_now;
	logic                  rsp_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign inverse   = inverse_q;
	assign status    = status_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	assign p_lo = prime_p[HALF_WIDTH-1:0];
	assign q_lo = prime_q[HALF_WIDTH-1:0];
	assign prod = pm1_q * qm1_q;

	rsape_step #(
		.PHI_WIDTH(PW)
	) u_step (
		.bs      (bs_q),
		.ts      (ts_q),
		.rem     (rem_q),
		.acc     (acc_q),
		.narrow  (state_q == S_SUB),
		.bs_eff  (bs_eff),
		.ts_eff  (ts_eff),
		.fits    (fits),
		.rem_diff(rem_diff),
		.acc_sum (acc_sum)
	);

	// Final fold: ta mod phi (ta never exceeds phi), then negate if needed.
	always_comb begin
		t_mod = (acc_q == phi_q) ? '0 : acc_q;
		d_val = (neg_a_q && t_mod != '0) ? (phi_q - t_mod) : t_mod;
		if (small_q) begin
			st_now = ST_SMALL_TOTIENT;
		end else if (rem_q != E_WIDTH'(1)) begin
			st_now = ST_NOT_INVERTIBLE;
		end else begin
			st_now = ST_OK;
		end
	end

	// Sequencer and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// Load a finished item into a free output register, else drop
			// the one that has just been taken.
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (small_q || phi_q < PW'(2)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					if (!fits) begin
						state_q <= (k_q == '0) ? S_NEXT : S_SUB;
					end
				end
				S_SUB: begin
					if (k_q == KW'(1)) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= (b_q == '0) ? S_DONE : S_ALIGN;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pm1_q   <= p_lo - HALF_WIDTH'(1);
				qm1_q   <= q_lo - HALF_WIDTH'(1);
				small_q <= (p_lo < HALF_WIDTH'(2)) || (q_lo < HALF_WIDTH'(2));
				rem_q   <= public_exp;
			end
			S_MUL: begin
				phi_q <= prod;
			end
			S_CHK: begin
				small_q <= small_q || (phi_q < PW'(2));
				// Reduce e modulo phi first; coefficients are not tracked here.
				bs_q    <= BSW'(phi_q);
				ts_q    <= '0;
				acc_q   <= '0;
				k_q     <= '0;
				red_q   <= 1'b1;
			end
			S_ALIGN: begin
				if (fits) begin
					bs_q <= bs_q << 1;
					ts_q <= ts_q << 1;
					k_q  <= k_q + KW'(1);
				end
			end
			S_SUB: begin
				bs_q <= bs_eff;
				ts_q <= ts_eff;
				k_q  <= k_q - KW'(1);
				if (fits) begin
					rem_q <= rem_diff;
					acc_q <= acc_sum;
				end
			end
			S_NEXT: begin
				if (red_q) begin
					// Start Euclid on (phi, e mod phi) with ta = 0, tb = 1.
					b_q     <= rem_q[PW-1:0];
					rem_q   <= E_WIDTH'(phi_q);
					acc_q   <= '0;
					tb_q    <= PW'(1);
					neg_a_q <= 1'b0;
					neg_b_q <= 1'b0;
					red_q   <= 1'b0;
				end else begin
					// Advance one round: (a, b) <= (b, r), (ta, tb) <= (tb, tn).
					b_q     <= rem_q[PW-1:0];
					rem_q   <= E_WIDTH'(b_q);
					acc_q   <= tb_q;
					tb_q    <= acc_q;
					neg_a_q <= neg_b_q;
					neg_b_q <= !neg_b_q;
				end
			end
			S_ROUND: begin
				bs_q <= BSW'(b_q);
				ts_q <= TSW'(tb_q);
				k_q  <= '0;
			end
			S_DONE: begin
				if (rsp_free) begin
					status_q  <= st_now;
					inverse_q <= (st_now == ST_OK) ? E_WIDTH'(d_val) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// The walk-down phase always has at least one quotient bit left.
	a_sub_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUB |-> k_q != '0)
		else $error("subtract phase entered with no quotient bits");

	// An accepted request always starts the totient multiply.
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_MUL)
		else $error("accepted request did not start");

	// Failed items report a zero exponent.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> inverse == '0)
		else $error("nonzero exponent on failure status");

	// A successful inverse is never zero and status is a defined code.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK && inverse != '0) ||
			status == ST_SMALL_TOTIENT || status == ST_NOT_INVERTIBLE)
		else $error("bad response status or zero inverse");

	// Euclid rounds keep the remainder above the divisor.
	a_euclid_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND && b_q != '0 |-> rem_q > E_WIDTH'(b_q))
		else $error("Euclid remainder not above divisor");

endmodule

// ----- src/rsape_step.sv -----
// ----------------------------------------------------------------------------
// rsape_step
// Shared compare-subtract unit: tests the aligned divisor against the
// remainder and forms the reduced remainder and the updated coefficient.
// ----------------------------------------------------------------------------
module rsape_step import rsape_pkg::*; #(
	parameter int PHI_WIDTH = 64
) (
	input  logic [E_WIDTH:0]     bs,
	input  logic [PHI_WIDTH:0]   ts,
	input  logic [E_WIDTH-1:0]   rem,
	input  logic [PHI_WIDTH-1:0] acc,
	input  logic                 narrow,
	output logic [E_WIDTH:0]     bs_eff,
	output logic [PHI_WIDTH:0]   ts_eff,
	output logic                 fits,
	output logic [E_WIDTH-1:0]   rem_diff,
	output logic [PHI_WIDTH-1:0] acc_sum
);

	logic [PHI_WIDTH:0] acc_wide;

	// Step the divisor down one place while retiring quotient bits.
	assign bs_eff   = narrow ? (bs >> 1) : bs;
	assign ts_eff   = narrow ? (ts >> 1) : ts;
	assign fits     = bs_eff <= {1'b0, rem};
	assign rem_diff = rem - bs_eff[E_WIDTH-1:0];
	assign acc_wide = (PHI_WIDTH + 1)'(acc) + ts_eff;
	assign acc_sum  = acc_wide[PHI_WIDTH-1:0];

endmodule

// ----- tb/tb_rsa_private_exponent.sv -----
// ----------------------------------------------------------------------------
// tb_rsa_private_exponent
// Self-checking bench for the private exponent (modular inverse) block.
// ----------------------------------------------------------------------------
// Requests carry p, q and e. A scoreboard works out d = e^-1 mod (p-1)(q-1)
// by extended Euclid on its own and queues the expected response for every
// accepted request. Each accepted response is checked field by field against
// the oldest entry. A short directed list covers the corner cases, then about
// 1900 random requests follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rsa_private_exponent import rsape_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_WIDTH = 32;
	localparam bit [E_WIDTH-1:0] HALF_MASK = (64'd1 << HALF_WIDTH) - 64'd1;
	localparam int NUM_RANDOM = 1900;
	// Covers the worst item plus the longest stall on each side.
	localparam int STALL_LIMIT = 20000;
	// Quiet window after the last response.
	localparam int DRAIN_CYCLES = 700;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [E_WIDTH-1:0] exponent;
		status_t            st;
	} exponent_result_t;

	// Expected responses, oldest first, plus the mismatch count.
	class exponent_scoreboard;
		exponent_result_t pending_q[$];
		int unsigned      mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Extended Euclid with coefficient magnitudes and a sign flag.
		function exponent_result_t compute_inverse(logic [31:0] p_in, logic [31:0] q_in,
				logic [E_WIDTH-1:0] e);
			bit [E_WIDTH-1:0] p, q, phi, a, b, ta, tb, qt, r, tn;
			bit               neg_a, neg_b, neg_t;
			exponent_result_t res;
			p = 64'(p_in) & HALF_MASK;
			q = 64'(q_in) & HALF_MASK;
			res.exponent = '0;
			res.st = ST_SMALL_TOTIENT;
			if (p < 2 || q < 2)
				return res;
			phi = (p - 64'd1) * (q - 64'd1);
			if (phi < 2)
				return res;
			a = phi;
			b = e % phi;
			ta = 64'd0;
			tb = 64'd1;
			neg_a = 1'b0;
			neg_b = 1'b0;
			while (b != 0) begin
				qt = a / b;
				r = a - qt * b;
				tn = ta + qt * tb;
				neg_t = !neg_b;
				a = b;
				b = r;
				ta = tb;
				neg_a = neg_b;
				tb = tn;
				neg_b = neg_t;
			end
			if (a != 64'd1) begin
				res.st = ST_NOT_INVERTIBLE;
				return res;
			end
			ta = ta % phi;
			if (neg_a && ta != 0)
				ta = phi - ta;
			res.exponent = ta;
			res.st = ST_OK;
			return res;
		endfunction

		function void note_request(logic [31:0] p, logic [31:0] q, logic [E_WIDTH-1:0] e);
			pending_q.push_back(compute_inverse(p, q, e));
		endfunction

		function void flag(string what, logic [E_WIDTH-1:0] want, logic [E_WIDTH-1:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH %s at %0t: expected %h, got %h", what, $realtime, want, got);
		endfunction

		function void check_response(logic [E_WIDTH-1:0] d, status_t st);
			exponent_result_t want;
			if (pending_q.size() == 0) begin
				flag("unexpected response", '0, d);
				return;
			end
			want = pending_q.pop_front();
			if (d !== want.exponent)
				flag("inverse", want.exponent, d);
			if (st !== want.st)
				flag("status", 64'(want.st), 64'(st));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [31:0]        prime_p = '0;
	logic [31:0]        prime_q = '0;
	logic [E_WIDTH-1:0] public_exp = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [E_WIDTH-1:0] inverse;
	status_t            status;

	exponent_scoreboard sb = new();
	int unsigned        idle_cycles = 0;

	rsa_private_exponent #(
		.HALF_WIDTH(HALF_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.prime_p   (prime_p),
		.prime_q   (prime_q),
		.public_exp(public_exp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.inverse   (inverse),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	// Factors of every bit length; small lengths keep most items fast.
	function automatic logic [31:0] random_factor();
		int unsigned pick;
		int unsigned w;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 32'($urandom_range(0, 3));
		if (pick <= 4)
			return $urandom;
		w = $urandom_range(2, 32);
		return $urandom & (32'hFFFF_FFFF >> (32 - w));
	endfunction

	// Odd exponents dominate so that many items are invertible; the rest are full
	// width, zero, multiples of the totient, its close neighbors or small values.
	function automatic logic [E_WIDTH-1:0] random_exponent(logic [E_WIDTH-1:0] phi);
		logic [E_WIDTH-1:0] wide;
		int unsigned        sh;
		wide = {$urandom, $urandom};
		sh = $urandom_range(0, 62);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return (wide >> sh) | 64'd1;
			4: return 64'd65537;
			5: return 64'd3;
			6: return wide;
			7: return phi * 64'($urandom_range(0, 3));
			8: return phi + 64'd1 - 64'($urandom_range(0, 2));
			default: return 64'($urandom_range(0, 255));
		endcase
	endfunction

	// Hold valid low for the gap, present the item, and wait for the handshake.
	task automatic send_request(logic [31:0] p, logic [31:0] q, logic [E_WIDTH-1:0] e,
			int unsigned gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		prime_p <= p;
		prime_q <= q;
		public_exp <= e;
		do @(posedge clk); while (!req_ready);
		sb.note_request(p, q, e);
	endtask

	// Drop valid and hold off until every queued response has come back.
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() != 0);
	endtask

	// Stimulus and end of run.
	initial begin
		logic [31:0]        p, q;
		logic [E_WIDTH-1:0] e, phi, pm, qm;
		int unsigned        gap;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small primes: zero, one, and p = q = 2 (totient one).
		send_request(32'd0, 32'd0, 64'd0, 0);
		send_request(32'd1, 32'd7, 64'd3, 0);
		send_request(32'd7, 32'd1, 64'd3, 0);
		send_request(32'd2, 32'd2, 64'd5, 0);
		// Smallest usable totients.
		send_request(32'd2, 32'd3, 64'd1, 0);
		send_request(32'd3, 32'd3, 64'd3, 0);
		send_request(32'd3, 32'd5, 64'd7, 0);
		// Textbook keys.
		send_request(32'd61, 32'd53, 64'd17, 0);
		send_request(32'd11, 32'd17, 64'd3, 0);
		// Exponent zero, a multiple of the totient, above the totient, shared factor.
		send_request(32'd61, 32'd53, 64'd0, 0);
		send_request(32'd61, 32'd53, 64'd3120, 0);
		send_request(32'd61, 32'd53, 64'd3120 * 5 + 64'd17, 0);
		send_request(32'd61, 32'd53, 64'd6, 0);
		// Full-width factors and exponents.
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd65537, 0);
		send_request(32'hFFFF_FFFB, 32'hFFFF_FFEF, 64'd65537, 0);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(32'hFFFF_FFFB, 32'hFFFF_FFEF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(32'h8000_0000, 32'h8000_0001, 64'd3, 0);
		send_request(32'd2, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 0);
		// Alternating bit patterns.
		send_request(32'h5555_5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 0);
		send_request(32'hAAAA_AAAB, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 0);
		hold_until_drained();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2)
				hold_until_drained();
			p = random_factor();
			q = random_factor();
			pm = 64'(p) & HALF_MASK;
			qm = 64'(q) & HALF_MASK;
			phi = (pm >= 2 && qm >= 2) ? (pm - 64'd1) * (qm - 64'd1) : 64'd0;
			e = random_exponent(phi);
			// Every third block of 150 items runs with no sender gaps.
			gap = ((i / 150) % 3 == 1) ? 0 : pick_gap();
			send_request(p, q, e, gap);
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: ready runs of random length with stalls between them; some
	// runs are long enough that no stall falls on a whole item.
	initial begin
		int unsigned run, stall;
		forever begin
			if ($urandom_range(0, 7) == 0)
				run = $urandom_range(500, 3000);
			else
				run = $urandom_range(1, 40);
			rsp_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Check every accepted response item.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(inverse, status);
	end

	// Watchdog: advance on cycles with no handshake, clear on any handshake.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

// ----- rsa_private_exponent.f -----
src/rsape_pkg.sv
src/rsape_step.sv
src/rsa_private_exponent.sv
tb/tb_rsa_private_exponent.sv
